// ===== hw/rtl/assert_macros.svh =====
// Assertion macros, included by the filter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("assert");
`define ASSERT_NEVER(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error("never");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, prop)
`endif
`endif

// ===== hw/rtl/kf_pkg.sv =====
// Types and constants of the position/velocity Kalman filter.
`default_nettype none
package kf_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned CfgW  = 31;

  typedef enum logic [1:0] {
    CFG_TIME_STEP = 2'd0,
    CFG_MEAS_NOISE = 2'd1,
    CFG_PROC_NOISE_POS = 2'd2,
    CFG_PROC_NOISE_VEL = 2'd3
  } cfg_idx_e;

  // Divider control between the sequencer and the divider
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctrl_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/kf_div.sv =====
// Radix-2 restoring divider, signed result truncated toward zero, saturated.
`default_nettype none
module kf_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [31:0] num_i,
  input  wire logic        [32:0] den_i,
  output kf_pkg::div_ctrl_t       ctrl_o,
  output logic signed      [31:0] quot_o
);
  localparam int unsigned NumW = 32 + FRAC_BITS;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] dvd_q, dvd_d;
  logic [33:0]     rem_q, rem_d;
  logic [32:0]     den_q, den_d;
  logic            neg_q, neg_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [33:0]     trial;
  logic [31:0]     mag;

  // one quotient bit a cycle
  always_comb begin
    dvd_d = dvd_q; rem_d = rem_q; den_d = den_q; neg_d = neg_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    mag = num_i[31] ? 32'(-num_i) : 32'(num_i);
    trial = {rem_q[32:0], dvd_q[NumW-1]} - {1'b0, den_q};
    if (start_i) begin
      dvd_d = {mag, {FRAC_BITS{1'b0}}};
      rem_d = '0; den_d = den_i; neg_d = num_i[31];
      cnt_d = CntW'(NumW); busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[33]) begin
        rem_d = trial;
        dvd_d = {dvd_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[32:0], dvd_q[NumW-1]};
        dvd_d = {dvd_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d; rem_q <= rem_d; den_q <= den_d; neg_q <= neg_d;
  end

  // sign and saturate the magnitude quotient
  always_comb begin
    logic signed [65:0] q;
    q = 66'(signed'({1'b0, dvd_q}));
    if (neg_q) q = -q;
    quot_o = kf_pkg::sat32(q);
  end

  assign ctrl_o.start = start_i;
  assign ctrl_o.busy  = busy_q;
  assign ctrl_o.done  = done_q;
endmodule
`default_nettype wire

// ===== hw/rtl/kalman_filter_pos_vel.sv =====
// Top level of the two-state position/velocity Kalman filter.
// Each item takes two divider passes for the gains, five correction steps, a load of
// the output register and seven prediction steps of one shared 32x32 multiplier with
// saturation, plus the accepting cycle; values are Q16.16 at the default FRAC_BITS.
// The result leaves through an output register, so a waiting result stalls the block
// only if it is still pending when the next one is ready. s_axis_tready is low from
// acceptance until the prediction of the next prior has finished.
`default_nettype none
module kalman_filter_pos_vel #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [30:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // control_accel, measured_velocity
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata   // velocity_estimate, position_estimate
);
`include "assert_macros.svh"
  typedef logic signed [31:0] s32_t;

  localparam s32_t OneFx = s32_t'(64'd1 << FRAC_BITS);
  localparam s32_t Vel0  = s32_t'((64'd78 * (64'd1 << FRAC_BITS) + 64'd50) / 64'd100);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001, ST_DIV = 5'b00010, ST_ALU = 5'b00100,
    ST_OUT = 5'b01000, ST_PRED = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [4:0] step_q, step_d;
  logic       kidx_q, kidx_d;

  logic [30:0] dt_q, r_q, qp_q, qv_q;
  s32_t xp_q, xv_q, p00_q, p01_q, p11_q;
  s32_t u_q, k0_q, k1_q, in_q, a_q, b_q, h_q, t_q;
  s32_t ex_q, ev_q;
  logic signed [35:0] acc_q;
  logic [32:0] den;
  logic        m_valid_q;
  logic [63:0] m_data_q;
  logic        out_load;

  // config writes
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q <= 31'(OneFx); r_q <= 31'(OneFx); qp_q <= '0; qv_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (kf_pkg::cfg_idx_e'(cfg_index_i))
        kf_pkg::CFG_TIME_STEP:      dt_q <= cfg_data_i;
        kf_pkg::CFG_MEAS_NOISE:     r_q  <= cfg_data_i;
        kf_pkg::CFG_PROC_NOISE_POS: qp_q <= cfg_data_i;
        kf_pkg::CFG_PROC_NOISE_VEL: qv_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // divider
  kf_pkg::div_ctrl_t dctl;
  s32_t quot;
  logic dstart;
  assign den = 33'(signed'(p11_q)) + 33'(r_q);
  kf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(kidx_d ? p11_q : p01_q),
    .den_i(den), .ctrl_o(dctl), .quot_o(quot));

  // shared multiplier: product of two operands, floor shift, saturate
  s32_t ma, mb;
  logic signed [63:0] prod;
  s32_t mres;
  always_comb begin
    prod = 64'(ma) * 64'(mb);
    mres = kf_pkg::sat32(66'(prod >>> FRAC_BITS));
  end
  function automatic s32_t add(input s32_t a, input s32_t b);
    return kf_pkg::sat32(66'(a) + 66'(b));
  endfunction
  function automatic s32_t sub(input s32_t a, input s32_t b);
    return kf_pkg::sat32(66'(a) - 66'(b));
  endfunction

  s32_t dts;
  assign dts = s32_t'({1'b0, dt_q});

  // multiplier operand select per step
  always_comb begin
    ma = '0; mb = '0;
    case (step_q)
      5'd0: begin ma = k0_q; mb = in_q; end
      5'd1: begin ma = k1_q; mb = in_q; end
      5'd2: begin ma = k0_q; mb = p01_q; end
      5'd3: begin ma = k0_q; mb = p11_q; end
      5'd4: begin ma = k1_q; mb = p11_q; end
      5'd5: begin ma = dts; mb = dts; end
      5'd6: begin ma = dts; mb = ev_q; end
      5'd7: begin ma = h_q; mb = u_q; end
      5'd8: begin ma = dts; mb = u_q; end
      5'd9: begin ma = dts; mb = p11_q; end
      5'd10: begin ma = dts; mb = b_q; end
      5'd11: begin ma = dts; mb = t_q; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; step_q <= '0; kidx_q <= 1'b0;
      xp_q <= '0; xv_q <= Vel0; p00_q <= OneFx;
      p01_q <= '0; p11_q <= OneFx;
    end else begin
      state_q <= state_d; step_q <= step_d; kidx_q <= kidx_d;
      if (state_q == ST_ALU) begin
        case (step_q)
          5'd0: ex_q <= add(xp_q, mres);
          5'd1: ev_q <= add(xv_q, mres);
          5'd2: a_q <= sub(p00_q, mres);
          5'd3: b_q <= sub(p01_q, mres);
          5'd4: p11_q <= sub(p11_q, mres);
          default: ;
        endcase
      end
      // multi-term sums are kept exact and saturated once
      if (state_q == ST_PRED) begin
        case (step_q)
          5'd6: acc_q <= 36'(ex_q) + 36'(mres);
          5'd7: xp_q <= kf_pkg::sat32(66'(acc_q + 36'(mres)));
          5'd8: xv_q <= add(ev_q, mres);
          5'd9: begin t_q <= add(b_q, mres); end
          5'd10: acc_q <= 36'(a_q) + 36'(mres);
          5'd11: begin
            p00_q <= kf_pkg::sat32(66'(acc_q + 36'(mres) + 36'(s32_t'({1'b0, qp_q}))));
            p01_q <= t_q;
            p11_q <= add(p11_q, s32_t'({1'b0, qv_q}));
          end
          default: ;
        endcase
      end
    end
  end
  // Note: the new p01 is b + dt*p11 with p11 corrected; step 9 multiplies dt by corrected p11.

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      u_q <= s_axis_tdata[63:32];
      in_q <= kf_pkg::sat32(66'(s32_t'(s_axis_tdata[31:0])) - 66'(xv_q));
    end
    if (dctl.done) begin
      if (den == '0) begin k0_q <= '0; k1_q <= '0; end
      else if (!kidx_q) k0_q <= quot;
      else k1_q <= quot;
    end
    if (state_q == ST_PRED && step_q == 5'd5)
      h_q <= kf_pkg::sat32(66'(prod >>> (FRAC_BITS + 1)));
    if (out_load) m_data_q <= {ev_q, ex_q};
  end

  // output register
  assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q; step_d = step_q; kidx_d = kidx_q; dstart = 1'b0;
    unique case (state_q)
      ST_IDLE: if (s_axis_tvalid) begin
        state_d = ST_DIV; kidx_d = 1'b0; dstart = 1'b1;
      end
      ST_DIV: if (dctl.done) begin
        if (!kidx_q) begin kidx_d = 1'b1; dstart = 1'b1; end
        else begin state_d = ST_ALU; step_d = '0; end
      end
      ST_ALU: if (step_q == 5'd4) state_d = ST_OUT; else step_d = step_q + 1'b1;
      ST_OUT: if (out_load) begin state_d = ST_PRED; step_d = 5'd5; end
      ST_PRED: if (step_q == 5'd11) state_d = ST_IDLE; else step_d = step_q + 1'b1;
      default: state_d = ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `ASSERT_NEVER(a_busy_ready, clk_i, rst_ni, s_axis_tready && dctl.busy)
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni,
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
  `ASSERT_CLK(a_accept_div, clk_i, rst_ni,
    (s_axis_tvalid && s_axis_tready) |=> dctl.busy)
endmodule
`default_nettype wire
